>>> rtl/npcs_pkg.sv
package npcs_pkg;

	// palette geometry
	localparam int PAL_ENTRIES = 256;
	localparam int PAL_AW      = $clog2(PAL_ENTRIES);

	// colour component and distance widths
	localparam int COMP_W = 8;
	localparam int SQ_W   = 2 * COMP_W;
	localparam int DIST_W = SQ_W + 3;

	// start value of the running best, above every real distance
	localparam logic [DIST_W-1:0] WORST_DIST = DIST_W'(256 * 256 * 4);

	// item operation codes
	localparam logic OP_LOAD  = 1'b0;
	localparam logic OP_QUERY = 1'b1;

	typedef logic [3*COMP_W-1:0] rgb_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SCAN,
		ST_DRAIN
	} state_t;

	// tag that travels with each palette read through the pipeline
	typedef struct packed {
		logic              valid;
		logic              last;
		logic [PAL_AW-1:0] idx;
	} tag_t;

endpackage

>>> rtl/npcs_palette_ram.sv
module npcs_palette_ram (
	input  logic                       clk,
	input  logic                       wr_en,
	input  logic [npcs_pkg::PAL_AW-1:0] wr_addr,
	input  npcs_pkg::rgb_t             wr_data,
	input  logic                       rd_en,
	input  logic [npcs_pkg::PAL_AW-1:0] rd_addr,
	output npcs_pkg::rgb_t             rd_data
);
	import npcs_pkg::*;

	rgb_t mem [PAL_ENTRIES];
	rgb_t rd_data_q;

	// write port
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	// registered read port
	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data_q <= mem[rd_addr];
		end
	end

	assign rd_data = rd_data_q;

endmodule

>>> rtl/npcs_sqdist.sv
module npcs_sqdist (
	input  logic                      clk,
	input  logic                      arst_n,
	input  npcs_pkg::rgb_t            target,
	input  npcs_pkg::rgb_t            entry,
	input  npcs_pkg::tag_t            tag_s1,
	output logic [npcs_pkg::SQ_W-1:0] sq_r_s2,
	output logic [npcs_pkg::SQ_W-1:0] sq_g_s2,
	output logic [npcs_pkg::SQ_W-1:0] sq_b_s2,
	output npcs_pkg::tag_t            tag_s2
);
	import npcs_pkg::*;

	logic [COMP_W-1:0] d_r, d_g, d_b;

	function automatic logic [COMP_W-1:0] abs_diff(input logic [COMP_W-1:0] a,
	                                               input logic [COMP_W-1:0] b);
		return (a > b) ? (a - b) : (b - a);
	endfunction

	// per-component absolute differences
	always_comb begin
		d_r = abs_diff(target[3*COMP_W-1:2*COMP_W], entry[3*COMP_W-1:2*COMP_W]);
		d_g = abs_diff(target[2*COMP_W-1:COMP_W], entry[2*COMP_W-1:COMP_W]);
		d_b = abs_diff(target[COMP_W-1:0], entry[COMP_W-1:0]);
	end

	// squares, registered
	always_ff @(posedge clk) begin
		sq_r_s2 <= SQ_W'(d_r * d_r);
		sq_g_s2 <= SQ_W'(d_g * d_g);
		sq_b_s2 <= SQ_W'(d_b * d_b);
	end

	// tag follows the squares
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tag_s2 <= '0;
		end else begin
			tag_s2 <= tag_s1;
		end
	end

endmodule

>>> rtl/nearest_palette_color_search_unit.sv
// Load items write one palette entry in the cycle they are accepted and leave the unit idle.
// A query scans all 256 entries, one palette memory read per cycle, and pulses done with
// best_index once the last entry has been compared; busy falls in that same cycle, so no
// new item is taken while a query is in flight. The palette memory has a single read port.
// Results cannot be held off by the receiver. Reset clears control state only; palette
// contents are undefined until loaded.
module nearest_palette_color_search_unit (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       start,
	output logic       busy,
	input  logic       op,
	input  logic [7:0] entry_index,
	input  logic [7:0] red,
	input  logic [7:0] green,
	input  logic [7:0] blue,
	output logic       done,
	output logic [7:0] best_index
);
	import npcs_pkg::*;

	state_t state_q, state_d;

	logic              accept;
	logic              load_wr;
	logic              query_go;
	logic              issue;
	logic [PAL_AW-1:0] cnt_q;
	logic              cnt_last;
	rgb_t              target_q;
	rgb_t              rd_data;
	tag_t              tag_s0, tag_s1, tag_s2;
	logic [SQ_W-1:0]   sq_r_s2, sq_g_s2, sq_b_s2;
	logic [DIST_W-1:0] dist_s2;
	logic [DIST_W-1:0] best_dist_q;
	logic [PAL_AW-1:0] best_idx_q;
	logic              better;
	logic [PAL_AW-1:0] new_best_idx;
	logic              done_q;
	logic [7:0]        best_index_q;

	// item handshake
	assign accept   = start && !busy;
	assign load_wr  = accept && (op == OP_LOAD) && (32'(entry_index) < PAL_ENTRIES);
	assign query_go = accept && (op == OP_QUERY);
	assign cnt_last = (cnt_q == PAL_AW'(PAL_ENTRIES - 1));

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (query_go) begin
					state_d = ST_SCAN;
				end
			end
			ST_SCAN: begin
				if (cnt_last) begin
					state_d = ST_DRAIN;
				end
			end
			ST_DRAIN: begin
				if (tag_s2.valid && tag_s2.last) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// state outputs
	always_comb begin
		busy  = 1'b1;
		issue = 1'b0;
		unique case (state_q)
			ST_IDLE:  busy  = 1'b0;
			ST_SCAN:  issue = 1'b1;
			ST_DRAIN: issue = 1'b0;
			default:  busy  = 1'b1;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// scan address counter and query target
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (query_go) begin
			cnt_q <= '0;
		end else if (issue) begin
			cnt_q <= cnt_q + 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (query_go) begin
			target_q <= {red, green, blue};
		end
	end

	// palette memory
	npcs_palette_ram u_ram (
		.clk     (clk),
		.wr_en   (load_wr),
		.wr_addr (PAL_AW'(entry_index)),
		.wr_data ({red, green, blue}),
		.rd_en   (issue),
		.rd_addr (cnt_q),
		.rd_data (rd_data)
	);

	// read tag, built with the read address and registered to align with the memory output
	always_comb begin
		tag_s0.valid = issue;
		tag_s0.last  = cnt_last;
		tag_s0.idx   = cnt_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tag_s1 <= '0;
		end else begin
			tag_s1 <= tag_s0;
		end
	end

	// squared component differences
	npcs_sqdist u_sqdist (
		.clk     (clk),
		.arst_n  (arst_n),
		.target  (target_q),
		.entry   (rd_data),
		.tag_s1  (tag_s1),
		.sq_r_s2 (sq_r_s2),
		.sq_g_s2 (sq_g_s2),
		.sq_b_s2 (sq_b_s2),
		.tag_s2  (tag_s2)
	);

	// sum and strict compare against the running best, lowest index wins ties
	assign dist_s2      = DIST_W'(sq_r_s2) + DIST_W'(sq_g_s2) + DIST_W'(sq_b_s2);
	assign better       = dist_s2 < best_dist_q;
	assign new_best_idx = better ? tag_s2.idx : best_idx_q;

	always_ff @(posedge clk) begin
		if (query_go) begin
			best_dist_q <= WORST_DIST;
			best_idx_q  <= '0;
		end else if (tag_s2.valid && better) begin
			best_dist_q <= dist_s2;
			best_idx_q  <= tag_s2.idx;
		end
	end

	// result strobe
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
		end else begin
			done_q <= tag_s2.valid && tag_s2.last;
		end
	end

	always_ff @(posedge clk) begin
		if (tag_s2.valid && tag_s2.last) begin
			best_index_q <= 8'(new_best_idx);
		end
	end

	assign done       = done_q;
	assign best_index = best_index_q;

	// a result only follows the end of a drain
	a_done_after_drain: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(state_q) == ST_DRAIN)
		else $error("result strobe without a finished scan");

	// no reads in flight while idle
	a_idle_empty: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_IDLE |-> !tag_s1.valid && !tag_s2.valid)
		else $error("pipeline not empty in idle");

	// an accepted query starts the scan at entry zero
	a_query_starts_scan: assert property (@(posedge clk) disable iff (!arst_n)
		query_go |=> state_q == ST_SCAN && cnt_q == '0)
		else $error("query did not start a scan");

	// no palette write while a scan is running
	a_no_write_in_scan: assert property (@(posedge clk) disable iff (!arst_n)
		load_wr |-> state_q == ST_IDLE)
		else $error("palette write during a scan");

endmodule

>>> bench/testbench.sv
`timescale 1ns / 100ps

// expected nearest-colour indices, built from a private copy of the palette
class palette_scoreboard;
	npcs_pkg::rgb_t palette [npcs_pkg::PAL_ENTRIES];
	logic [7:0]     expected_best [$];
	int unsigned    failures;
	int unsigned    loads;
	int unsigned    queries;
	int unsigned    checked;
	int unsigned    exact_hits;
	int unsigned    tie_hits;

	// lowest index at the smallest squared rgb distance
	function logic [7:0] nearest_entry(input logic [7:0] r, input logic [7:0] g,
			input logic [7:0] b);
		int unsigned best_dist;
		int unsigned sq_dist;
		int unsigned hits;
		int          best;
		int          dr;
		int          dg;
		int          db;
		best_dist = 256 * 256 * 4;
		best      = 0;
		hits      = 0;
		for (int i = 0; i < npcs_pkg::PAL_ENTRIES; i++) begin
			dr      = int'(r) - int'(palette[i][23:16]);
			dg      = int'(g) - int'(palette[i][15:8]);
			db      = int'(b) - int'(palette[i][7:0]);
			sq_dist = dr * dr + dg * dg + db * db;
			if (sq_dist < best_dist) begin
				best_dist = sq_dist;
				best      = i;
				hits      = 1;
			end else if (sq_dist == best_dist) begin
				hits++;
			end
		end
		if (best_dist == 0)
			exact_hits++;
		if (hits > 1)
			tie_hits++;
		return 8'(best);
	endfunction

	// an accepted item: loads update the palette, queries queue a prediction
	function void note_item(input logic o, input logic [7:0] idx, input logic [7:0] r,
			input logic [7:0] g, input logic [7:0] b);
		if (o == npcs_pkg::OP_LOAD) begin
			if (int'(idx) < npcs_pkg::PAL_ENTRIES)
				palette[idx] = {r, g, b};
			loads++;
		end else begin
			expected_best.push_back(nearest_entry(r, g, b));
			queries++;
		end
	endfunction

	// a strobed result against the oldest outstanding query
	function void check_result(input logic [7:0] got);
		logic [7:0] want;
		if (expected_best.size() == 0) begin
			$display("%0t: best_index %0d with no query outstanding", $time, got);
			failures++;
		end else begin
			want = expected_best.pop_front();
			checked++;
			if (got !== want) begin
				$display("%0t: best_index mismatch, expected %0d, actual %0d",
					$time, want, got);
				failures++;
			end
		end
	endfunction

	function int pending();
		return expected_best.size();
	endfunction
endclass

module testbench;
	import npcs_pkg::*;

	localparam int WATCHDOG_LIMIT = 2000;
	localparam int SETTLE_CYCLES  = 300;

	logic       clk;
	logic       arst_n;
	logic       start;
	logic       busy;
	logic       op;
	logic [7:0] entry_index;
	logic [7:0] red;
	logic [7:0] green;
	logic [7:0] blue;
	logic       done;
	logic [7:0] best_index;

	palette_scoreboard board = new;
	int unsigned       idle_cycles = 0;
	bit                quiet_stretch = 1'b0;

	nearest_palette_color_search_unit dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.start       (start),
		.busy        (busy),
		.op          (op),
		.entry_index (entry_index),
		.red         (red),
		.green       (green),
		.blue        (blue),
		.done        (done),
		.best_index  (best_index)
	);

	// clock
	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// observe accepted items and results on the edge
	always @(posedge clk) begin
		if (arst_n) begin
			if (done)
				board.check_result(best_index);
			if (start && !busy)
				board.note_item(op, entry_index, red, green, blue);
		end
	end

	// watchdog on cycles with no handshake at all
	always @(posedge clk) begin
		if (!arst_n || (start && !busy) || done) begin
			idle_cycles <= 0;
		end else if (idle_cycles >= WATCHDOG_LIMIT) begin
			$display("%0t: no item or result for %0d cycles", $time, WATCHDOG_LIMIT);
			$display("== FAIL ==");
			$finish;
		end else begin
			idle_cycles <= idle_cycles + 1;
		end
	end

	// mostly no gap, some short, a few long
	function automatic int gap_cycles();
		int roll;
		if (quiet_stretch)
			return 0;
		roll = $urandom_range(0, 99);
		if (roll < 50)
			return 0;
		else if (roll < 90)
			return $urandom_range(1, 3);
		return $urandom_range(10, 60);
	endfunction

	// a colour a few steps away from another, clamped per component
	function automatic rgb_t near_colour(input rgb_t c);
		int   v;
		rgb_t n;
		for (int k = 0; k < 3; k++) begin
			v = int'(c[8*k +: 8]) + int'($urandom_range(0, 6)) - 3;
			if (v < 0)
				v = 0;
			if (v > 255)
				v = 255;
			n[8*k +: 8] = 8'(v);
		end
		return n;
	endfunction

	// present one item, hold until taken, then maybe idle
	task automatic send_item(input logic o, input logic [7:0] idx, input rgb_t c);
		int gap;
		start       <= 1'b1;
		op          <= o;
		entry_index <= idx;
		red         <= c[23:16];
		green       <= c[15:8];
		blue        <= c[7:0];
		do @(posedge clk); while (busy);
		gap = gap_cycles();
		if (gap > 0) begin
			start       <= 1'b0;
			op          <= 1'($urandom);
			entry_index <= 8'($urandom);
			{red, green, blue} <= 24'($urandom);
			repeat (gap) @(posedge clk);
		end
	endtask

	// hold off until every query has answered
	task automatic drain();
		start <= 1'b0;
		do @(posedge clk); while (board.pending() != 0);
	endtask

	// mixed loads and queries, queries aimed at, near or away from entries
	task automatic random_items(input int n);
		int   pick;
		rgb_t c;
		repeat (n) begin
			if ($urandom_range(0, 99) < 35) begin
				pick = $urandom_range(0, 9);
				if (pick < 4)
					c = board.palette[$urandom_range(0, 255)];
				else if (pick < 7)
					c = near_colour(board.palette[$urandom_range(0, 255)]);
				else
					c = rgb_t'($urandom);
				send_item(OP_QUERY, 8'($urandom), c);
			end else begin
				if ($urandom_range(0, 3) == 0)
					c = board.palette[$urandom_range(0, 255)];
				else
					c = rgb_t'($urandom);
				send_item(OP_LOAD, 8'($urandom), c);
			end
			if ($urandom_range(0, 99) == 0)
				quiet_stretch = !quiet_stretch;
		end
	endtask

	// stimulus
	initial begin
		rgb_t few_colours [4];
		few_colours = '{24'h000000, 24'hffffff, 24'h808080, 24'h00ff80};
		arst_n      = 1'b0;
		start       = 1'b0;
		op          = OP_LOAD;
		entry_index = 8'h00;
		red         = 8'h00;
		green       = 8'h00;
		blue        = 8'h00;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// every entry written before the first query: black at 0, white at 255
		for (int i = 0; i < PAL_ENTRIES; i++) begin
			if (i == 0)
				send_item(OP_LOAD, 8'(i), 24'h000000);
			else if (i == PAL_ENTRIES - 1)
				send_item(OP_LOAD, 8'(i), 24'hffffff);
			else
				send_item(OP_LOAD, 8'(i), rgb_t'($urandom));
		end

		// corners of the colour cube and exact matches at both ends
		send_item(OP_QUERY, 8'hff, 24'h000000);
		send_item(OP_QUERY, 8'h00, 24'hffffff);
		send_item(OP_QUERY, 8'h5a, 24'h00ff00);
		send_item(OP_QUERY, 8'ha5, 24'hff00ff);
		// two identical entries, exact hit must give the lower index
		send_item(OP_LOAD, 8'd10, 24'h808080);
		send_item(OP_LOAD, 8'd20, 24'h808080);
		send_item(OP_QUERY, 8'h00, 24'h808080);
		send_item(OP_QUERY, 8'h00, 24'h7f8081);
		// target halfway between two entries
		send_item(OP_LOAD, 8'd30, 24'h646464);
		send_item(OP_LOAD, 8'd40, 24'h666464);
		send_item(OP_QUERY, 8'h00, 24'h656464);
		// white now at both ends of the palette, then black at the top in place of white
		send_item(OP_LOAD, 8'd0, 24'hffffff);
		send_item(OP_QUERY, 8'h00, 24'hffffff);
		send_item(OP_QUERY, 8'h00, 24'hfefefe);
		send_item(OP_LOAD, 8'd255, 24'h000000);
		send_item(OP_QUERY, 8'hff, 24'h000000);
		send_item(OP_QUERY, 8'hff, 24'h010101);
		drain();

		random_items(600);
		drain();

		// palette of only a few colours, so most queries see ties
		for (int i = 0; i < PAL_ENTRIES; i++)
			send_item(OP_LOAD, 8'(i), few_colours[$urandom_range(0, 3)]);
		repeat (80) begin
			if ($urandom_range(0, 1) == 0)
				send_item(OP_QUERY, 8'($urandom), few_colours[$urandom_range(0, 3)]);
			else
				send_item(OP_QUERY, 8'($urandom), rgb_t'($urandom));
		end

		random_items(400);
		drain();
		repeat (SETTLE_CYCLES) @(posedge clk);

		$display("palette loads %0d, queries %0d, results checked %0d",
			board.loads, board.queries, board.checked);
		$display("queries with an exact entry %0d, with tied nearest entries %0d",
			board.exact_hits, board.tie_hits);
		if (board.failures == 0 && board.pending() == 0) begin
			$display("== PASS ==");
		end else begin
			$display("== FAIL ==");
		end
		$finish;
	end
endmodule

>>> nearest_palette_color_search_unit.f
rtl/npcs_pkg.sv
rtl/npcs_palette_ram.sv
rtl/npcs_sqdist.sv
rtl/nearest_palette_color_search_unit.sv
bench/testbench.sv
